/* rtl/core/pdaf_pkg.sv */
// ----------------------------------------------------------------------------
// pdaf_pkg
// Shared types, codes and helpers for the percent-decode ASCII filter.
// ----------------------------------------------------------------------------
package pdaf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned REM_W   = 3;
    localparam int unsigned VAL_W   = 31;

    // escape phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PERCENT = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HIGH    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DROP    = 2'd3;

    localparam logic [BYTE_W-1:0] PERCENT_CHAR = 8'h25;

    typedef struct packed {
        logic               pass;
        logic [BYTE_W-1:0]  data;
        logic [PHASE_W-1:0] phase_next;
        logic [NIB_W-1:0]   nibble_next;
    } esc_out_t;

    typedef struct packed {
        logic             emit;
        logic [REM_W-1:0] rem_next;
        logic [VAL_W-1:0] value_next;
    } utf_out_t;

    typedef struct packed {
        logic             ok;
        logic [NIB_W-1:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = NIB_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = NIB_W'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = NIB_W'(c - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* rtl/core/pdaf_escape.sv */
// ----------------------------------------------------------------------------
// pdaf_escape
// Percent-escape decoder: decides whether a byte passes on, and its value.
// ----------------------------------------------------------------------------
module pdaf_escape (
    input  logic [pdaf_pkg::BYTE_W-1:0]  in_byte,
    input  logic [pdaf_pkg::PHASE_W-1:0] phase,
    input  logic [pdaf_pkg::NIB_W-1:0]   high_nibble,
    output pdaf_pkg::esc_out_t           esc
);

    pdaf_pkg::hex_t hex;

    always_comb begin
        hex             = pdaf_pkg::hex_digit(in_byte);
        esc.pass        = 1'b0;
        esc.data        = in_byte;
        esc.phase_next  = phase;
        esc.nibble_next = high_nibble;
        case (phase)
            pdaf_pkg::PH_IDLE: begin
                if (in_byte == pdaf_pkg::PERCENT_CHAR) begin
                    esc.phase_next = pdaf_pkg::PH_PERCENT;
                end else begin
                    esc.pass = 1'b1;
                end
            end
            pdaf_pkg::PH_PERCENT: begin
                if (hex.ok) begin
                    esc.nibble_next = hex.val;
                    esc.phase_next  = pdaf_pkg::PH_HIGH;
                end else begin
                    esc.phase_next = pdaf_pkg::PH_DROP;
                end
            end
            pdaf_pkg::PH_HIGH: begin
                esc.phase_next = pdaf_pkg::PH_IDLE;
                if (hex.ok) begin
                    esc.data = {high_nibble, hex.val};
                    esc.pass = 1'b1;
                end
            end
            default: begin
                esc.phase_next = pdaf_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/pdaf_utf.sv */
// ----------------------------------------------------------------------------
// pdaf_utf
// UTF-8 sequence assembler; flags characters of value 0x7F or less.
// ----------------------------------------------------------------------------
module pdaf_utf (
    input  logic                        pass,
    input  logic [pdaf_pkg::BYTE_W-1:0] c,
    input  logic [pdaf_pkg::REM_W-1:0]  rem,
    input  logic [pdaf_pkg::VAL_W-1:0]  value,
    output pdaf_pkg::utf_out_t          utf
);

    always_comb begin
        utf.emit       = 1'b0;
        utf.rem_next   = rem;
        utf.value_next = value;
        if (pass) begin
            if (rem == '0) begin
                if (!c[7]) begin
                    utf.value_next = pdaf_pkg::VAL_W'(c);
                    utf.emit       = 1'b1;
                end else if (c[7:6] == 2'b10 || c[7:1] == 7'h7F) begin
                    // stray continuation, or 0xFE/0xFF: dropped
                end else if (c[7:5] == 3'b110) begin
                    utf.value_next = pdaf_pkg::VAL_W'(c[4:0]);
                    utf.rem_next   = 3'd1;
                end else if (c[7:4] == 4'b1110) begin
                    utf.value_next = pdaf_pkg::VAL_W'(c[3:0]);
                    utf.rem_next   = 3'd2;
                end else if (c[7:3] == 5'b11110) begin
                    utf.value_next = pdaf_pkg::VAL_W'(c[2:0]);
                    utf.rem_next   = 3'd3;
                end else if (c[7:2] == 6'b111110) begin
                    utf.value_next = pdaf_pkg::VAL_W'(c[1:0]);
                    utf.rem_next   = 3'd4;
                end else begin
                    utf.value_next = pdaf_pkg::VAL_W'(c[0]);
                    utf.rem_next   = 3'd5;
                end
            end else if (c[7:6] != 2'b10) begin
                // broken sequence: abandon, byte dropped
                utf.rem_next = '0;
            end else begin
                utf.value_next = {value[pdaf_pkg::VAL_W-7:0], c[5:0]};
                utf.rem_next   = rem - 3'd1;
                utf.emit       = (rem == 3'd1) &&
                                 (utf.value_next[pdaf_pkg::VAL_W-1:pdaf_pkg::CHAR_W] == '0);
            end
        end
    end

endmodule

/* rtl/core/percent_decode_ascii_filter_unit.sv */
// ----------------------------------------------------------------------------
// percent_decode_ascii_filter_unit
// URL percent decoder followed by a UTF-8 filter passing ASCII only.
//
//   channel | dir | ports                                    | role
//   s_      | in  | s_valid s_ready s_in_byte s_string_end   | raw text bytes
//   m_      | out | m_valid m_ready m_out_char m_char_valid  | ASCII results
//           |     | m_end_flag                               |
//
// One byte per cycle sustained while results are not stalled. A byte is held
// in an input register, then the escape and UTF-8 logic writes the result
// register and state. Reset clears both valid flags and all decode state.
// A stalled result stalls the input register, which still takes one byte
// before s_ready drops.
// ----------------------------------------------------------------------------
module percent_decode_ascii_filter_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pdaf_pkg::BYTE_W-1:0] s_in_byte,
    input  logic                        s_string_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pdaf_pkg::CHAR_W-1:0] m_out_char,
    output logic                        m_char_valid,
    output logic                        m_end_flag
);

    logic                         in_valid_reg;
    logic [pdaf_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                         in_end_reg;

    logic [pdaf_pkg::PHASE_W-1:0] phase_reg;
    logic [pdaf_pkg::NIB_W-1:0]   nibble_reg;
    logic [pdaf_pkg::REM_W-1:0]   rem_reg;
    logic [pdaf_pkg::VAL_W-1:0]   value_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [pdaf_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         out_cv_reg;
    logic                         out_end_reg;

    pdaf_pkg::esc_out_t esc;
    pdaf_pkg::utf_out_t utf;
    logic               advance;
    logic               produce;

    pdaf_escape u_escape (
        .in_byte     (in_byte_reg),
        .phase       (phase_reg),
        .high_nibble (nibble_reg),
        .esc         (esc)
    );

    pdaf_utf u_utf (
        .pass  (esc.pass),
        .c     (esc.data),
        .rem   (rem_reg),
        .value (value_reg),
        .utf   (utf)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign produce = utf.emit || in_end_reg;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        if (advance) begin
            out_valid_next = produce;
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= pdaf_pkg::PH_IDLE;
            nibble_reg    <= '0;
            rem_reg       <= '0;
            value_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                if (in_end_reg) begin
                    // end of string: back to reset state
                    phase_reg  <= pdaf_pkg::PH_IDLE;
                    nibble_reg <= '0;
                    rem_reg    <= '0;
                    value_reg  <= '0;
                end else begin
                    phase_reg  <= esc.phase_next;
                    nibble_reg <= esc.nibble_next;
                    rem_reg    <= utf.rem_next;
                    value_reg  <= utf.value_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_string_end;
        end
        if (advance && produce) begin
            out_char_reg <= utf.emit ? utf.value_next[pdaf_pkg::CHAR_W-1:0] : '0;
            out_cv_reg   <= utf.emit;
            out_end_reg  <= in_end_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_char   = out_char_reg;
    assign m_char_valid = out_cv_reg;
    assign m_end_flag   = out_end_reg;

endmodule

/* rtl/core/pdaf_checker.sv */
// ----------------------------------------------------------------------------
// pdaf_checker
// Port-level checks for the percent-decode ASCII filter.
// ----------------------------------------------------------------------------
module pdaf_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [pdaf_pkg::BYTE_W-1:0] s_in_byte,
    input logic                        s_string_end,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pdaf_pkg::CHAR_W-1:0] m_out_char,
    input logic                        m_char_valid,
    input logic                        m_end_flag
);

    // a waiting input transfer holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte) && $stable(s_string_end))
        else $error("input changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) &&
                                $stable(m_char_valid) && $stable(m_end_flag))
        else $error("result changed while stalled");

    // results with no character carry zero
    a_zero_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_char_valid |-> m_out_char == '0)
        else $error("non-zero char on empty result");

    // every result either carries a character or closes a string
    a_no_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_char_valid || m_end_flag)
        else $error("result with neither char nor end");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind percent_decode_ascii_filter_unit pdaf_checker u_pdaf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_in_byte    (s_in_byte),
    .s_string_end (s_string_end),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_char   (m_out_char),
    .m_char_valid (m_char_valid),
    .m_end_flag   (m_end_flag)
);

/* test/percent_decode_ascii_filter_unit_tb.sv */
// ----------------------------------------------------------------------------
// percent_decode_ascii_filter_unit_tb
// Self-checking bench for the percent decoder and ASCII-only UTF-8 filter.
// Bytes of URL strings are pushed through the input channel. A local decoder
// model predicts every result, and each result transfer is checked field by
// field against the oldest prediction. Directed strings come first, then
// random strings built from escapes, UTF-8 sequences and noise, with random
// stalls on both channels, a long output stall and a full-rate tail.
// ----------------------------------------------------------------------------
module percent_decode_ascii_filter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic [pdaf_pkg::CHAR_W-1:0] ch;
        logic                        valid;
        logic                        eos;
    } ascii_result_t;

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        s_valid      = 1'b0;
    logic                        s_ready;
    logic [pdaf_pkg::BYTE_W-1:0] s_in_byte    = '0;
    logic                        s_string_end = 1'b0;
    logic                        m_valid;
    logic                        m_ready      = 1'b0;
    logic [pdaf_pkg::CHAR_W-1:0] m_out_char;
    logic                        m_char_valid;
    logic                        m_end_flag;

    // decoder model state
    logic [pdaf_pkg::PHASE_W-1:0] esc_phase  = pdaf_pkg::PH_IDLE;
    logic [pdaf_pkg::NIB_W-1:0]   esc_nibble = '0;
    logic [pdaf_pkg::REM_W-1:0]   utf_left   = '0;
    logic [pdaf_pkg::VAL_W-1:0]   utf_acc    = '0;

    ascii_result_t               ascii_expected_q[$];
    logic [pdaf_pkg::BYTE_W-1:0] text_q[$];
    int unsigned                 bytes_sent     = 0;
    int unsigned                 mismatch_count = 0;
    bit                          src_idle_en    = 1'b1;
    bit                          sink_idle_en   = 1'b1;
    bit                          hold_request   = 1'b0;

    percent_decode_ascii_filter_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_string_end (s_string_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_char_valid (m_char_valid),
        .m_end_flag   (m_end_flag)
    );

    always #5 aclk = ~aclk;

    // 0..15 for a hex digit, 16 otherwise
    function automatic logic [4:0] hex_val(input logic [pdaf_pkg::BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") return 5'(c - 8'h30);
        if (c >= "A" && c <= "F") return 5'(c - 8'h37);
        if (c >= "a" && c <= "f") return 5'(c - 8'h57);
        return 5'd16;
    endfunction

    function automatic logic [pdaf_pkg::BYTE_W-1:0] hex_char(
        input logic [pdaf_pkg::NIB_W-1:0] nib);
        if (nib < 10) return 8'h30 + nib;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // Advances the decoder model by one byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [pdaf_pkg::BYTE_W-1:0] raw,
                                       input logic last, output ascii_result_t r);
        logic [pdaf_pkg::BYTE_W-1:0] c;
        logic [4:0]                  d;
        logic                        fwd;
        logic                        emit;
        c    = raw;
        d    = hex_val(raw);
        fwd  = 1'b0;
        emit = 1'b0;
        case (esc_phase)
            pdaf_pkg::PH_IDLE: begin
                if (raw == pdaf_pkg::PERCENT_CHAR) esc_phase = pdaf_pkg::PH_PERCENT;
                else fwd = 1'b1;
            end
            pdaf_pkg::PH_PERCENT: begin
                if (d[4]) begin
                    esc_phase = pdaf_pkg::PH_DROP;
                end else begin
                    esc_nibble = d[3:0];
                    esc_phase  = pdaf_pkg::PH_HIGH;
                end
            end
            pdaf_pkg::PH_HIGH: begin
                esc_phase = pdaf_pkg::PH_IDLE;
                if (!d[4]) begin
                    c   = {esc_nibble, d[3:0]};
                    fwd = 1'b1;
                end
            end
            default: esc_phase = pdaf_pkg::PH_IDLE;
        endcase
        if (fwd) begin
            if (utf_left == 0) begin
                if (!c[7]) begin
                    utf_acc = pdaf_pkg::VAL_W'(c);
                    emit    = 1'b1;
                end else if (c[7:6] == 2'b10 || c[7:1] == 7'h7F) begin
                    // stray continuation or 0xFE/0xFF: dropped
                end else if (c[7:5] == 3'b110) begin
                    utf_acc  = pdaf_pkg::VAL_W'(c[4:0]);
                    utf_left = 3'd1;
                end else if (c[7:4] == 4'b1110) begin
                    utf_acc  = pdaf_pkg::VAL_W'(c[3:0]);
                    utf_left = 3'd2;
                end else if (c[7:3] == 5'b11110) begin
                    utf_acc  = pdaf_pkg::VAL_W'(c[2:0]);
                    utf_left = 3'd3;
                end else if (c[7:2] == 6'b111110) begin
                    utf_acc  = pdaf_pkg::VAL_W'(c[1:0]);
                    utf_left = 3'd4;
                end else begin
                    utf_acc  = pdaf_pkg::VAL_W'(c[0]);
                    utf_left = 3'd5;
                end
            end else if (c[7:6] != 2'b10) begin
                utf_left = '0;
            end else begin
                utf_acc  = {utf_acc[pdaf_pkg::VAL_W-7:0], c[5:0]};
                utf_left = utf_left - 3'd1;
                emit     = (utf_left == 0) && (utf_acc <= pdaf_pkg::VAL_W'(8'h7F));
            end
        end
        r.ch    = emit ? utf_acc[pdaf_pkg::CHAR_W-1:0] : '0;
        r.valid = emit;
        r.eos   = last;
        if (last) begin
            esc_phase  = pdaf_pkg::PH_IDLE;
            esc_nibble = '0;
            utf_left   = '0;
            utf_acc    = '0;
        end
        return emit || last;
    endfunction

    // --- text building --------------------------------------------------

    function automatic void push_escaped(input logic [pdaf_pkg::BYTE_W-1:0] b);
        text_q.push_back(pdaf_pkg::PERCENT_CHAR);
        text_q.push_back(hex_char(b[7:4]));
        text_q.push_back(hex_char(b[3:0]));
    endfunction

    function automatic logic [pdaf_pkg::BYTE_W-1:0] non_hex_byte();
        logic [pdaf_pkg::BYTE_W-1:0] b;
        logic [4:0]                  d;
        do begin
            b = 8'($urandom_range(0, 255));
            d = hex_val(b);
        end while (!d[4]);
        return b;
    endfunction

    // n-byte UTF-8 encoding of v, cut to keep bytes, raw or percent-escaped
    function automatic void push_utf8(input int unsigned n, input logic [31:0] v,
                                      input int unsigned keep, input bit escaped);
        logic [pdaf_pkg::BYTE_W-1:0] b;
        for (int k = 0; k < n && k < keep; k++) begin
            if (k == 0)
                b = 8'(~(8'hFF >> n) | ((v >> (6 * (n - 1))) & (8'hFF >> (n + 1))));
            else
                b = 8'(8'h80 | ((v >> (6 * (n - 1 - k))) & 8'h3F));
            if (escaped) push_escaped(b);
            else text_q.push_back(b);
        end
    endfunction

    function automatic void build_text();
        int unsigned n;
        logic [31:0] v;
        text_q.delete();
        repeat ($urandom_range(1, 6)) begin
            n = $urandom_range(2, 6);
            v = $urandom_range(0, 1) ? 32'($urandom_range(0, 127)) : $urandom;
            case ($urandom_range(0, 15))
                0, 1, 2, 3: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                4:          text_q.push_back(8'($urandom_range(0, 127)));
                5, 6, 7:    push_escaped(8'($urandom_range(0, 255)));
                8:          push_utf8(n, v, n, 1'b1);
                9, 10:      push_utf8(n, v, n, 1'b0);
                11: begin
                    text_q.push_back(pdaf_pkg::PERCENT_CHAR);
                    if ($urandom_range(0, 1)) begin
                        text_q.push_back(non_hex_byte());
                    end else begin
                        text_q.push_back(hex_char(4'($urandom_range(0, 15))));
                        if ($urandom_range(0, 3) != 0) text_q.push_back(non_hex_byte());
                        continue;
                    end
                    if ($urandom_range(0, 3) != 0) text_q.push_back(8'($urandom_range(0, 255)));
                end
                12: begin
                    if ($urandom_range(0, 2) == 0)
                        text_q.push_back(8'($urandom_range(8'hFE, 8'hFF)));
                    else
                        text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                13: begin
                    // sequence cut short by a non-continuation byte, or by the end
                    push_utf8(n, v, $urandom_range(1, n - 1), 1'b0);
                    if ($urandom_range(0, 3) != 0) begin
                        if ($urandom_range(0, 1))
                            text_q.push_back(8'($urandom_range(0, 127)));
                        else
                            text_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                    end
                end
                default: text_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // --- drivers ----------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [pdaf_pkg::BYTE_W-1:0] b, input logic last);
        ascii_result_t r;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_in_byte    <= b;
        s_string_end <= last;
        do @(posedge aclk); while (!s_ready);
        if (decode_byte(b, last, r)) ascii_expected_q.push_back(r);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_list(input logic [pdaf_pkg::BYTE_W-1:0] bytes[$],
                             input bit end_last);
        foreach (bytes[i]) send_byte(bytes[i], end_last && (i == bytes.size() - 1));
    endtask

    // --- tests ------------------------------------------------------------

    task automatic test_escapes();
        // lower-case escape of 0x7F, escaped '%' not re-escaped, bad first digit,
        // bad second digit, raw NUL, then a string ending on a lone '%'
        send_list('{"%", "7", "f", "%", "2", "5", "4", "1", "%", "G", "x",
                    "%", "4", "Z", 8'h00, "%"}, 1'b1);
        send_list('{"%", "0", "0"}, 1'b1);
    endtask

    task automatic test_utf8();
        // stray continuation, 0xFE/0xFF, broken sequence, overlong 'A',
        // character above 0x7F, six-byte overlong ending the string
        send_list('{8'h80, 8'hFE, 8'hFF, 8'hC3, "A", 8'hC1, 8'h81, 8'hC3, 8'hA9,
                    8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h81}, 1'b1);
    endtask

    task automatic test_random_strings();
        while (bytes_sent < 760) begin
            src_idle_en  = $urandom_range(0, 3) != 0;
            sink_idle_en = $urandom_range(0, 3) != 0;
            build_text();
            send_text();
        end
    endtask

    task automatic test_backpressure();
        int unsigned start;
        start        = bytes_sent;
        src_idle_en  = 1'b0;
        hold_request = 1'b1;
        while (bytes_sent < start + 40) begin
            build_text();
            send_text();
        end
        src_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        build_text();
        send_text();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (ascii_expected_q.size() != 0) @(negedge aclk);
        build_text();
        send_text();
    endtask

    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (bytes_sent < 1050) begin
            build_text();
            send_text();
        end
    endtask

    // --- result side ------------------------------------------------------

    initial begin : sink
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        ascii_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (ascii_expected_q.size() == 0) begin
                $error("unexpected result: out_char %0h char_valid %0b end_flag %0b",
                       m_out_char, m_char_valid, m_end_flag);
                mismatch_count++;
            end else begin
                want = ascii_expected_q.pop_front();
                if (m_out_char !== want.ch) begin
                    $error("out_char: expected %0h, actual %0h", want.ch, m_out_char);
                    mismatch_count++;
                end
                if (m_char_valid !== want.valid) begin
                    $error("char_valid: expected %0b, actual %0b", want.valid, m_char_valid);
                    mismatch_count++;
                end
                if (m_end_flag !== want.eos) begin
                    $error("end_flag: expected %0b, actual %0b", want.eos, m_end_flag);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : main
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_escapes();
        test_utf8();
        test_random_strings();
        test_backpressure();
        test_drain_pause();
        test_full_rate();
        s_valid <= 1'b0;
        while (ascii_expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/pdaf_pkg.sv
rtl/core/pdaf_escape.sv
rtl/core/pdaf_utf.sv
rtl/core/percent_decode_ascii_filter_unit.sv
rtl/core/pdaf_checker.sv
test/percent_decode_ascii_filter_unit_tb.sv
